// ===== src/pulse_width_waveform_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse width waveform generator
// Concurrent checks clocked by clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_WIDTH_WAVEFORM_GENERATOR_MACROS_SVH
`define PULSE_WIDTH_WAVEFORM_GENERATOR_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define PWWG_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Whenever the trigger holds, the condition must hold in the same cycle.
`define PWWG_ASSERT_IMPLIES(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

`endif

// ===== src/pwwg_pkg.sv =====
// ----------------------------------------------------------------------------
// pwwg_pkg
// Widths, codes, reset values and the sine table arithmetic shared by the
// pulse width waveform generator files.
// ----------------------------------------------------------------------------
`default_nettype none

package pwwg_pkg;

	// Field and register widths.
	localparam int unsigned IDX_W      = 32;
	localparam int unsigned FREQ_W     = 24;
	localparam int unsigned VOL_W      = 16;
	localparam int unsigned OUT_W      = 16;
	localparam int unsigned SR_W       = 18;
	localparam int unsigned SHAPE_W    = 2;
	localparam int unsigned PW_W       = 15;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 18;

	// Derived datapath widths.
	localparam int unsigned FREQ_FRAC_W = 8;                  // frequency is in 1/256 Hz
	localparam int unsigned D_W         = SR_W + FREQ_FRAC_W; // period denominator
	localparam int unsigned RED_W       = D_W + 2;            // radix-4 trial value
	localparam int unsigned FRAC_W      = 15;                 // pulse width unity = 2^15
	localparam int unsigned E_W         = D_W + FRAC_W;       // scaled part boundary
	localparam int unsigned QUO_W       = 16;                 // Q0.16 position in part
	localparam int unsigned MAG_W       = 15;                 // waveform magnitude
	localparam int unsigned ACC_W       = MAG_W + VOL_W;      // volume product
	localparam int unsigned LFSR_W      = 32;
	localparam int unsigned CNT_W       = 5;

	// Step counts of the serial phases, stored as the last count value.
	localparam logic [CNT_W-1:0] REDUCE_LAST = CNT_W'(IDX_W / 2 - 1);
	localparam logic [CNT_W-1:0] MODMUL_LAST = CNT_W'(FREQ_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(QUO_W - 1);
	localparam logic [CNT_W-1:0] SCALE_LAST  = CNT_W'(VOL_W / 2 - 1);

	// Reset values and constants.
	localparam logic [SR_W-1:0]   SR_RESET   = SR_W'(48000);
	localparam logic [PW_W-1:0]   PW_RESET   = PW_W'(16384);
	localparam logic [LFSR_W-1:0] LFSR_SEED  = LFSR_W'(1);
	localparam logic [LFSR_W-1:0] LFSR_MASK  = 32'hD000_0001;
	localparam logic [MAG_W-1:0]  FULL_SCALE = 15'h7FFF;
	localparam logic [MAG_W+1:0]  TRI_MID    = 17'd32768;

	// Sine table generation, evaluated at elaboration only.
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_SINE     = 2'd0,
		SHAPE_SQUARE   = 2'd1,
		SHAPE_TRIANGLE = 2'd2,
		SHAPE_NOISE    = 2'd3
	} shape_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE = 2'd0,
		REG_WAVE_SHAPE  = 2'd1,
		REG_PULSE_WIDTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PART_NONE   = 2'd0,
		PART_FIRST  = 2'd1,
		PART_SECOND = 2'd2
	} part_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MODMUL,
		ST_CMP,
		ST_DIV,
		ST_SHAPE,
		ST_MAG,
		ST_SCALE,
		ST_OUT
	} state_t;

	// Q2.30 Taylor series of sin(x) to the x^15 term, scaled to Q0.15.
	function automatic logic [MAG_W-1:0] sine_taylor(input logic [63:0] x);
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] val;
		term = x;
		sum  = x;
		for (int i = 1; i <= 7; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / TAYLOR_DIV[i];
			if ((i & 1) != 0) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		val = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return val[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/pwwg_req_if.sv =====
// ----------------------------------------------------------------------------
// pwwg_req_if
// Request channel: one item carries a sample index, a frequency and a volume.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwwg_req_if;
	import pwwg_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  sample_index;
	logic [FREQ_W-1:0] frequency;
	logic [VOL_W-1:0]  volume;

	modport source (output valid, output sample_index, output frequency, output volume,
		input ready);
	modport sink (input valid, input sample_index, input frequency, input volume,
		output ready);
endinterface

`default_nettype wire

// ===== src/pwwg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pwwg_rsp_if
// Result channel: one item carries a signed Q1.15 output sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwwg_rsp_if;
	import pwwg_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== src/pwwg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// pwwg_sine_rom
// Half-sine table over [0, pi) with a registered read port. The content is
// built at elaboration from the same series used to define the waveform.
// ----------------------------------------------------------------------------
`default_nettype none

module pwwg_sine_rom #(
	parameter int unsigned TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic [TABLE_BITS-1:0]          addr,
	output logic [pwwg_pkg::MAG_W-1:0]     data
);
	import pwwg_pkg::*;

	localparam int unsigned DEPTH = 1 << TABLE_BITS;

	typedef logic [MAG_W-1:0] sine_rom_t [DEPTH];

	// The table is symmetric about pi/2; the upper half mirrors the lower one.
	function automatic sine_rom_t build_rom();
		sine_rom_t   tbl;
		logic [63:0] kk;
		logic [63:0] x;
		for (int k = 0; k < DEPTH; k++) begin
			kk = (k > DEPTH / 2) ? 64'(DEPTH - k) : 64'(k);
			x = (PI_Q30 * kk) / DEPTH;
			tbl[k] = sine_taylor(x);
		end
		return tbl;
	endfunction

	localparam sine_rom_t ROM = build_rom();

	logic [MAG_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ===== src/pulse_width_waveform_generator.sv =====
// ----------------------------------------------------------------------------
// pulse_width_waveform_generator
// Variable-symmetry oscillator: sine, square, triangle or held noise over a
// period split into two parts by the pulse width, scaled by the volume.
//
//   channel   dir   handshake       payload
//   request   in    valid / ready   sample_index, frequency, volume
//   result    out   valid / ready   sample_out
//   cfg       in    cfg_wen         cfg_idx, cfg_wdata
//
// For each item, 16 radix-4 steps reduce the index modulo the period, 24 bit
// steps multiply by the frequency, 16 steps divide out the position in its part,
// 8 radix-4 steps apply the volume, and five further states remain. A zero
// frequency or sample rate goes from idle straight to the output state.
// Reset is asynchronous and returns the registers and noise state to defaults.
// The next item runs while a result waits; a result still waiting stalls the end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pulse_width_waveform_generator_macros.svh"

module pulse_width_waveform_generator #(
	parameter int unsigned SINE_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [pwwg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [pwwg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pwwg_req_if.sink                        request,
	pwwg_rsp_if.source                      result
);
	import pwwg_pkg::*;

	// Control and configuration.
	state_t            state_q;
	state_t            state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [SR_W-1:0]   sample_rate_q;
	shape_t            shape_q;
	logic [PW_W-1:0]   pw_q;

	// Noise state.
	logic [LFSR_W-1:0]       lfsr_q;
	part_t                   noise_part_q;
	logic signed [OUT_W-1:0] held_noise_q;

	// Item datapath.
	logic [IDX_W-1:0]  idx_q;
	logic [FREQ_W-1:0] freq_q;
	logic [VOL_W-1:0]  vol_q;
	logic [D_W-1:0]    d_q;
	logic [RED_W-1:0]  d3_q;
	logic [D_W-1:0]    rem_q;
	logic [D_W-1:0]    r_q;
	logic [PW_W:0]     pws_q;
	logic [E_W-1:0]    e_q;
	logic [E_W-1:0]    drem_q;
	logic [E_W-1:0]    den_q;
	logic [QUO_W-1:0]  quo_q;
	logic              second_q;
	logic              draw_q;
	logic [MAG_W-1:0]  mag_q;
	logic [MAG_W+1:0]  mag3_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic              res_valid_q;
	logic [OUT_W-1:0]  res_q;

	// Combinational datapath.
	logic              accept;
	logic              zero_item;
	logic              out_free;
	logic [RED_W-1:0]  d_ext;
	logic [RED_W-1:0]  d2_ext;
	logic [RED_W-1:0]  red_t;
	logic [D_W-1:0]    rem_nxt;
	logic [RED_W-1:0]  mm_t;
	logic [D_W-1:0]    r_nxt;
	logic [E_W-1:0]    e_nxt;
	logic [E_W-1:0]    pos;
	logic [E_W-1:0]    full_span;
	logic              second_w;
	part_t             part_w;
	logic [E_W:0]      div_t;
	logic              div_ge;
	logic [E_W:0]      div_sub;
	logic [LFSR_W-1:0] lfsr_nxt;
	logic [MAG_W-1:0]  noise_v;
	logic [MAG_W-1:0]  rom_data;
	logic [MAG_W+1:0]  tri_lo;
	logic [MAG_W-1:0]  tri_lo_mag;
	logic [OUT_W-1:0]  held_abs;
	logic [MAG_W-1:0]  shape_mag;
	logic              shape_neg;
	logic [ACC_W-1:0]  acc_add;
	logic [ACC_W-1:0]  acc_nxt;
	logic [OUT_W-1:0]  res_abs;
	logic [OUT_W-1:0]  res_val;

	assign accept    = request.valid && (state_q == ST_IDLE);
	assign zero_item = (request.frequency == '0) || (sample_rate_q == '0);
	assign out_free  = !res_valid_q || result.ready;

	// Radix-4 reduction of the index: the trial value stays below 4d.
	assign d_ext  = {2'b00, d_q};
	assign d2_ext = {1'b0, d_q, 1'b0};
	assign red_t  = {rem_q, idx_q[IDX_W-1 -: 2]};

	always_comb begin
		priority if (red_t >= d3_q) begin
			rem_nxt = D_W'(red_t - d3_q);
		end else if (red_t >= d2_ext) begin
			rem_nxt = D_W'(red_t - d2_ext);
		end else if (red_t >= d_ext) begin
			rem_nxt = D_W'(red_t - d_ext);
		end else begin
			rem_nxt = red_t[D_W-1:0];
		end
	end

	// Modular multiply by the frequency, one bit per step: 2r + (index mod d) < 3d.
	assign mm_t = {1'b0, r_q, 1'b0} + (freq_q[FREQ_W-1] ? d_ext & '0 | {2'b00, rem_q} : '0);

	always_comb begin
		priority if (mm_t >= d2_ext) begin
			r_nxt = D_W'(mm_t - d2_ext);
		end else if (mm_t >= d_ext) begin
			r_nxt = D_W'(mm_t - d_ext);
		end else begin
			r_nxt = mm_t[D_W-1:0];
		end
	end

	// Part boundary pulse_width * d, built one bit per step during the reduction.
	assign e_nxt = {e_q[E_W-2:0], 1'b0} + (pws_q[PW_W] ? {{FRAC_W{1'b0}}, d_q} : '0);

	assign pos       = {r_q, {FRAC_W{1'b0}}};
	assign full_span = {d_q, {FRAC_W{1'b0}}};
	assign second_w  = (pos >= e_q);
	assign part_w    = second_w ? PART_SECOND : PART_FIRST;

	// Restoring division, one quotient bit per step.
	assign div_t   = {drem_q, 1'b0};
	assign div_ge  = (div_t >= {1'b0, den_q});
	assign div_sub = div_t - {1'b0, den_q};

	assign lfsr_nxt = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
	assign noise_v  = (lfsr_q[MAG_W-1:0] == FULL_SCALE) ? '0 : lfsr_q[MAG_W-1:0];

	pwwg_sine_rom #(
		.TABLE_BITS(SINE_TABLE_BITS)
	) u_sine_rom (
		.clk  (clk),
		.addr (quo_q[QUO_W-1 -: SINE_TABLE_BITS]),
		.data (rom_data)
	);

	// Waveform magnitude and sign. The triangle is a - 1/2 in the first part and
	// 1/2 - a in the second; only the distance from mid-scale needs clamping.
	assign tri_lo     = TRI_MID - {1'b0, quo_q};
	assign tri_lo_mag = tri_lo[MAG_W] ? FULL_SCALE : tri_lo[MAG_W-1:0];
	assign held_abs   = held_noise_q[OUT_W-1] ? OUT_W'(-held_noise_q) : held_noise_q;

	always_comb begin
		unique case (shape_q)
			SHAPE_SINE: begin
				shape_mag = rom_data;
				shape_neg = second_q;
			end
			SHAPE_SQUARE: begin
				shape_mag = FULL_SCALE;
				shape_neg = !second_q;
			end
			SHAPE_TRIANGLE: begin
				shape_mag = quo_q[QUO_W-1] ? quo_q[MAG_W-1:0] : tri_lo_mag;
				shape_neg = (second_q == quo_q[QUO_W-1]);
			end
			SHAPE_NOISE: begin
				shape_mag = held_abs[MAG_W-1:0];
				shape_neg = held_noise_q[OUT_W-1];
			end
			default: begin
				shape_mag = '0;
				shape_neg = 1'b0;
			end
		endcase
	end

	// Volume product, two volume bits per step from the top.
	always_comb begin
		unique case (vol_q[VOL_W-1 -: 2])
			2'd0:    acc_add = '0;
			2'd1:    acc_add = ACC_W'(mag_q);
			2'd2:    acc_add = ACC_W'({mag_q, 1'b0});
			default: acc_add = ACC_W'(mag3_q);
		endcase
	end

	assign acc_nxt = {acc_q[ACC_W-3:0], 2'b00} + acc_add;
	assign res_abs = {1'b0, acc_q[ACC_W-1:VOL_W]};
	assign res_val = neg_q ? OUT_W'(-res_abs) : res_abs;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (request.valid) begin
					state_d = zero_item ? ST_OUT : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (cnt_q == '0) begin
					state_d = ST_MODMUL;
				end
			end
			ST_MODMUL: begin
				if (cnt_q == '0) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_SHAPE;
				end
			end
			ST_SHAPE: begin
				state_d = ST_MAG;
			end
			ST_MAG: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control, configuration and noise state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			sample_rate_q <= SR_RESET;
			shape_q       <= SHAPE_SINE;
			pw_q          <= PW_RESET;
			lfsr_q        <= LFSR_SEED;
			noise_part_q  <= PART_NONE;
			held_noise_q  <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_reg_t'(cfg_idx))
					REG_SAMPLE_RATE: sample_rate_q <= cfg_wdata[SR_W-1:0];
					REG_WAVE_SHAPE:  shape_q <= shape_t'(cfg_wdata[SHAPE_W-1:0]);
					REG_PULSE_WIDTH: pw_q <= cfg_wdata[PW_W-1:0];
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= REDUCE_LAST;
				end
				ST_REDUCE: begin
					cnt_q <= (cnt_q == '0) ? MODMUL_LAST : cnt_q - 1'b1;
				end
				ST_MODMUL: begin
					cnt_q <= cnt_q - 1'b1;
				end
				ST_CMP: begin
					cnt_q <= DIV_LAST;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (draw_q) begin
						lfsr_q <= lfsr_nxt;
					end
				end
				ST_SHAPE: begin
					// A noise value is drawn once on entering a different part.
					if (shape_q == SHAPE_NOISE) begin
						if (draw_q) begin
							held_noise_q <= second_q ? OUT_W'(-{1'b0, noise_v})
								: {1'b0, noise_v};
						end
						noise_part_q <= second_q ? PART_SECOND : PART_FIRST;
					end
				end
				ST_MAG: begin
					cnt_q <= SCALE_LAST;
				end
				ST_SCALE: begin
					cnt_q <= cnt_q - 1'b1;
				end
				ST_OUT: begin
					cnt_q <= REDUCE_LAST;
				end
				default: begin
				end
			endcase

			if ((state_q == ST_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Item payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q  <= request.sample_index;
					freq_q <= request.frequency;
					vol_q  <= request.volume;
					d_q    <= {sample_rate_q, {FREQ_FRAC_W{1'b0}}};
					d3_q   <= {2'b00, sample_rate_q, {FREQ_FRAC_W{1'b0}}}
						+ {1'b0, sample_rate_q, {(FREQ_FRAC_W + 1){1'b0}}};
					rem_q  <= '0;
					r_q    <= '0;
					e_q    <= '0;
					pws_q  <= {1'b0, pw_q};
					acc_q  <= '0;
					neg_q  <= 1'b0;
				end
			end
			ST_REDUCE: begin
				idx_q <= {idx_q[IDX_W-3:0], 2'b00};
				rem_q <= rem_nxt;
				e_q   <= e_nxt;
				pws_q <= {pws_q[PW_W-1:0], 1'b0};
			end
			ST_MODMUL: begin
				r_q    <= r_nxt;
				freq_q <= {freq_q[FREQ_W-2:0], 1'b0};
			end
			ST_CMP: begin
				second_q <= second_w;
				draw_q   <= (shape_q == SHAPE_NOISE) && (noise_part_q != part_w);
				drem_q   <= second_w ? pos - e_q : pos;
				den_q    <= second_w ? full_span - e_q : e_q;
			end
			ST_DIV: begin
				drem_q <= div_ge ? div_sub[E_W-1:0] : div_t[E_W-1:0];
				quo_q  <= {quo_q[QUO_W-2:0], div_ge};
			end
			ST_SHAPE: begin
			end
			ST_MAG: begin
				mag_q  <= shape_mag;
				mag3_q <= {2'b00, shape_mag} + {1'b0, shape_mag, 1'b0};
				neg_q  <= shape_neg;
				acc_q  <= '0;
			end
			ST_SCALE: begin
				acc_q <= acc_nxt;
				vol_q <= {vol_q[VOL_W-3:0], 2'b00};
			end
			ST_OUT: begin
				if (out_free) begin
					res_q <= res_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign request.ready     = (state_q == ST_IDLE);
	assign result.valid      = res_valid_q;
	assign result.sample_out = res_q;

	`PWWG_ASSERT_ALWAYS(a_lfsr_nonzero, lfsr_q != '0, "noise LFSR reached the all-zero state")
	`PWWG_ASSERT_IMPLIES(a_mod_below_period, state_q == ST_MODMUL, (rem_q < d_q) && (r_q < d_q), "modular remainder not below the period")
	`PWWG_ASSERT_IMPLIES(a_div_rem_below, state_q == ST_DIV, drem_q < den_q, "division remainder not below the divisor")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Pulse width waveform generator testbench
// Sends tone requests through the request channel and predicts each output
// sample from its own fixed-point model of the oscillator, noise generator
// included. Every result is compared in order. Random gaps on the sender and
// random stalls on the receiver are applied over phases that change the
// sample rate, the wave shape and the pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import pwwg_pkg::*;

	localparam int          SINE_BITS   = 10;
	localparam int          SINE_N      = 1 << SINE_BITS;
	localparam logic [63:0] SIN_PI_FX   = 64'd3373259426;
	localparam logic [63:0] SIN_ONE_FX  = 64'd1 << 30;
	localparam logic [31:0] NOISE_TAPS  = 32'hD000_0001;
	localparam int          STUCK_LIMIT = 4000;

	typedef struct packed {
		logic [IDX_W-1:0]  sample_index;
		logic [FREQ_W-1:0] frequency;
		logic [VOL_W-1:0]  volume;
	} tone_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pwwg_req_if request_ch ();
	pwwg_rsp_if result_ch ();

	pulse_width_waveform_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.request   (request_ch),
		.result    (result_ch)
	);

	// Oscillator state as the block should hold it.
	logic [SR_W-1:0]   model_rate;
	shape_t            model_shape;
	logic [PW_W-1:0]   model_pw;
	int                held_noise;
	part_t             noise_side;
	logic [31:0]       lfsr_reg;
	int                sine_rom [SINE_N];

	tone_req_t               pending_tones [$];
	logic signed [OUT_W-1:0] expected_samples [$];
	logic signed [OUT_W-1:0] want_sample;

	int send_gap_pct;
	int recv_stall_pct;
	int errors;
	int tones_sent;
	int samples_checked;
	int settings_used;
	int noise_redraws;
	int shape_items [4];
	int stuck_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Half-sine entry by Q2.30 Taylor series, folded about the quarter period.
	function automatic int half_sine(input int k);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] val;
		int          folded;
		folded = (k > SINE_N / 2) ? SINE_N - k : k;
		x = (SIN_PI_FX * 64'(folded)) / 64'(SINE_N);
		term = x;
		sum = x;
		for (int i = 1; i <= 7; i++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * i) * (2 * i + 1));
			if (i % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		val = (sum * 64'd32767 + (SIN_ONE_FX >> 1)) >> 30;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return int'(val);
	endfunction

	function automatic int next_noise();
		logic [31:0] v;
		for (int i = 0; i < 16; i++) begin
			lfsr_reg = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ NOISE_TAPS) : (lfsr_reg >> 1);
		end
		v = lfsr_reg & 32'h7FFF;
		if (v == 32'h7FFF) begin
			v = 32'd0;
		end
		noise_redraws++;
		return int'(v);
	endfunction

	function automatic logic signed [OUT_W-1:0] oscillator_sample(input tone_req_t t);
		logic [63:0] period_den;
		logic [63:0] pos;
		logic [63:0] bound;
		logic [63:0] frac;
		logic [63:0] mag;
		logic        in_second;
		int          wave;
		if (t.frequency == '0 || model_rate == '0) begin
			return '0;
		end
		period_den = 64'(model_rate) << FREQ_FRAC_W;
		pos = ((64'(t.sample_index) * 64'(t.frequency)) % period_den) << 15;
		bound = 64'(model_pw) * period_den;
		in_second = (pos >= bound);
		// The position inside its own part, as a Q0.16 fraction of that part.
		if (in_second) begin
			frac = ((pos - bound) << 16) / ((64'd32768 - 64'(model_pw)) * period_den);
		end else begin
			frac = (pos << 16) / bound;
		end
		if (frac > 64'hFFFF) begin
			frac = 64'hFFFF;
		end
		case (model_shape)
			SHAPE_SINE: begin
				wave = sine_rom[frac[15:0] >> (16 - SINE_BITS)];
				if (in_second) begin
					wave = -wave;
				end
			end
			SHAPE_SQUARE: begin
				wave = in_second ? 32767 : -32767;
			end
			SHAPE_TRIANGLE: begin
				wave = in_second ? 32768 - int'(frac) : int'(frac) - 32768;
				if (wave > 32767) begin
					wave = 32767;
				end
				if (wave < -32767) begin
					wave = -32767;
				end
			end
			default: begin
				// A fresh noise value is drawn only when the part changes.
				if (in_second) begin
					if (noise_side != PART_SECOND) begin
						held_noise = -next_noise();
					end
					noise_side = PART_SECOND;
				end else begin
					if (noise_side != PART_FIRST) begin
						held_noise = next_noise();
					end
					noise_side = PART_FIRST;
				end
				wave = held_noise;
			end
		endcase
		mag = (64'((wave < 0) ? -wave : wave) * 64'(t.volume)) >> 16;
		return (wave < 0) ? OUT_W'(64'd0 - mag) : OUT_W'(mag);
	endfunction

	function automatic logic [FREQ_W-1:0] pick_frequency();
		case ($urandom_range(5))
			0, 1: return FREQ_W'($urandom_range(5120000, 5120));
			2: return FREQ_W'($urandom);
			3: return FREQ_W'((32'(model_rate) << 8) / $urandom_range(8, 2));
			4: return FREQ_W'($urandom_range(3, 0));
			default: return {FREQ_W{1'b1}};
		endcase
	endfunction

	task automatic add_tone(input logic [IDX_W-1:0] idx, input logic [FREQ_W-1:0] freq,
		input logic [VOL_W-1:0] vol);
		pending_tones.push_back({idx, freq, vol});
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_wen <= 1'b1;
		cfg_idx <= which;
		cfg_wdata <= value;
		case (which)
			REG_SAMPLE_RATE: model_rate = value[SR_W-1:0];
			REG_WAVE_SHAPE:  model_shape = shape_t'(value[SHAPE_W-1:0]);
			default:         model_pw = value[PW_W-1:0];
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [SR_W-1:0] rate, input shape_t shape,
		input logic [PW_W-1:0] pw);
		write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rate));
		write_reg(REG_WAVE_SHAPE, CFG_DATA_W'(shape));
		write_reg(REG_PULSE_WIDTH, CFG_DATA_W'(pw));
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	task automatic wait_drained();
		while (pending_tones.size() != 0 || expected_samples.size() != 0 || request_ch.valid) begin
			@(posedge clk);
		end
	endtask

	// Mostly runs of consecutive sample indices of one note, the rest loose items.
	task automatic queue_random(input int count);
		int                left;
		int                run;
		logic [IDX_W-1:0]  start;
		logic [FREQ_W-1:0] freq;
		logic [VOL_W-1:0]  vol;
		left = count;
		while (left > 0) begin
			freq = pick_frequency();
			case ($urandom_range(9))
				0: vol = '0;
				1: vol = '1;
				default: vol = VOL_W'($urandom);
			endcase
			if ($urandom_range(9) < 7) begin
				run = $urandom_range(16, 1);
				if (run > left) begin
					run = left;
				end
				start = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(64)) : IDX_W'($urandom);
				for (int j = 0; j < run; j++) begin
					add_tone(start + IDX_W'(j), freq, vol);
				end
			end else begin
				run = 1;
				add_tone(IDX_W'($urandom), freq, vol);
			end
			left -= run;
		end
	endtask

	task automatic run_phase(input logic [SR_W-1:0] rate, input shape_t shape,
		input logic [PW_W-1:0] pw, input int gap, input int stall, input int count);
		configure(rate, shape, pw);
		send_gap_pct = gap;
		recv_stall_pct = stall;
		queue_random(count);
		wait_drained();
	endtask

	// Request driver; the expected sample is worked out when an item is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (request_ch.valid && request_ch.ready) begin
				expected_samples.push_back(oscillator_sample({request_ch.sample_index,
					request_ch.frequency, request_ch.volume}));
				shape_items[model_shape]++;
				tones_sent++;
			end
			if (!request_ch.valid || request_ch.ready) begin
				if (pending_tones.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					request_ch.valid <= 1'b1;
					{request_ch.sample_index, request_ch.frequency, request_ch.volume}
						<= pending_tones.pop_front();
				end else begin
					request_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample_out %0d with nothing outstanding",
						$time, result_ch.sample_out);
					errors++;
				end else begin
					want_sample = expected_samples.pop_front();
					samples_checked++;
					if (result_ch.sample_out !== want_sample) begin
						$display("%0t: sample_out mismatch, expected %0d, got %0d",
							$time, want_sample, result_ch.sample_out);
						errors++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (request_ch.valid && request_ch.ready)
			|| (result_ch.valid && result_ch.ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
	end

	initial begin
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
		end
		$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_idx = REG_SAMPLE_RATE;
		cfg_wdata = '0;
		request_ch.valid = 1'b0;
		request_ch.sample_index = '0;
		request_ch.frequency = '0;
		request_ch.volume = '0;
		result_ch.ready = 1'b0;
		model_rate = SR_W'(48000);
		model_shape = SHAPE_SINE;
		model_pw = PW_W'(16384);
		held_noise = 0;
		noise_side = PART_NONE;
		lfsr_reg = 32'd1;
		errors = 0;
		tones_sent = 0;
		samples_checked = 0;
		settings_used = 0;
		noise_redraws = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		foreach (shape_items[i]) begin
			shape_items[i] = 0;
		end
		for (int k = 0; k < SINE_N; k++) begin
			sine_rom[k] = half_sine(k);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults after reset: sine at 48 kHz with an even split.
		// At 48 kHz a phase of 6144000 out of 12288000 lands on the part boundary.
		add_tone('0, 24'd112640, 16'hFFFF);
		add_tone(32'd1, 24'd6144000, 16'hFFFF);
		add_tone(32'd2, 24'd3072000, 16'hFFFF);
		add_tone(32'd1, 24'd6143999, 16'hFFFF);
		add_tone('1, '1, 16'hFFFF);
		add_tone('1, 24'd1, '0);
		add_tone(32'd12345, '0, 16'hFFFF);
		add_tone(32'd3, 24'd1024000, 16'hFFFF);
		add_tone(32'd9, 24'd1024000, 16'h8000);
		add_tone(32'd1, 24'd1, 16'd1);
		wait_drained();

		configure(SR_W'(48000), SHAPE_SQUARE, PW_W'(16384));
		add_tone('0, 24'd112640, 16'hFFFF);
		add_tone(32'd1, 24'd6144000, 16'hFFFF);
		add_tone(32'd5, 24'd112640, 16'h7FFF);
		wait_drained();

		configure(SR_W'(48000), SHAPE_TRIANGLE, PW_W'(16384));
		add_tone('0, 24'd112640, 16'hFFFF);
		add_tone(32'd3, 24'd1024000, 16'hFFFF);
		add_tone(32'd1, 24'd6144000, 16'hFFFF);
		add_tone(32'd1, 24'd6143999, 16'hFFFF);
		wait_drained();

		// Noise holds its value within a part and redraws on each change of part.
		configure(SR_W'(48000), SHAPE_NOISE, PW_W'(16384));
		add_tone('0, 24'd112640, 16'hFFFF);
		add_tone(32'd1, 24'd112640, 16'hFFFF);
		add_tone(32'd1, 24'd6144000, 16'hFFFF);
		add_tone('0, 24'd112640, 16'hFFFF);
		wait_drained();

		// A zero sample rate silences the output like a zero frequency.
		configure('0, SHAPE_SINE, PW_W'(16384));
		add_tone(32'd100, 24'd5000, 16'hFFFF);
		add_tone('1, '1, 16'hFFFF);
		wait_drained();

		// With a zero pulse width the whole period is the second part.
		configure(SR_W'(48000), SHAPE_TRIANGLE, '0);
		add_tone('0, 24'd112640, 16'hFFFF);
		add_tone(32'd1, 24'd6144000, 16'hFFFF);
		wait_drained();

		run_phase(SR_W'(48000), SHAPE_SINE, PW_W'(16384), 0, 0, 75);
		run_phase(SR_W'(44100), SHAPE_SQUARE, PW_W'(8192), 62, 0, 75);
		run_phase(SR_W'(96000), SHAPE_TRIANGLE, PW_W'(24576), 0, 62, 75);
		run_phase(SR_W'(48000), SHAPE_NOISE, PW_W'(16384), 6, 6, 75);
		run_phase(SR_W'(1), SHAPE_SINE, PW_W'(1), 0, 0, 75);
		run_phase(SR_W'(192000), SHAPE_TRIANGLE, PW_W'(32767), 62, 0, 75);
		run_phase(SR_W'(22050), SHAPE_NOISE, PW_W'(4000), 0, 62, 75);
		run_phase({SR_W{1'b1}}, SHAPE_SQUARE, PW_W'(30000), 6, 6, 75);
		run_phase(SR_W'($urandom_range(192000, 1000)), SHAPE_NOISE,
			PW_W'($urandom_range(32767, 1)), 0, 0, 75);
		run_phase(SR_W'(48000), SHAPE_SINE, '0, 62, 0, 75);
		run_phase('0, SHAPE_TRIANGLE, PW_W'(16384), 0, 62, 75);
		run_phase(SR_W'($urandom_range(192000, 1000)), shape_t'($urandom_range(3)),
			PW_W'($urandom_range(32767, 1)), 6, 6, 75);

		repeat (200) @(posedge clk);

		$display("Covered %0d tone requests over %0d register settings, %0d samples checked.",
			tones_sent, settings_used, samples_checked);
		$display("Items per shape: sine %0d, square %0d, triangle %0d, noise %0d (%0d redraws).",
			shape_items[SHAPE_SINE], shape_items[SHAPE_SQUARE], shape_items[SHAPE_TRIANGLE],
			shape_items[SHAPE_NOISE], noise_redraws);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
